### src/assert_macros.svh
// Assertion macros used by the RTL of the header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BHP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BHP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BHP_ASSERT(lbl, clk, rst_n, prop)
`define BHP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### src/bhp_pkg.sv
// Constants and types shared by the header parser modules.
package bhp_pkg;

  localparam logic [7:0] MAGIC0_BYTE = 8'h00;
  localparam logic [7:0] MAGIC1_BYTE = 8'h09;
  localparam logic [15:0] SKIP_LEN = 16'd9;
  localparam logic [15:0] DATE_LEN = 16'd11;
  localparam logic [15:0] TIME_LEN = 16'd9;

  localparam logic [7:0] A_HDR0 = 8'h00;
  localparam logic [7:0] A_HDR1 = 8'h01;
  localparam logic [7:0] A_HDR2 = 8'h61;
  localparam logic [7:0] B_TAG = 8'h62;
  localparam logic [7:0] C_TAG = 8'h63;
  localparam logic [7:0] D_TAG = 8'h64;

  localparam logic [7:0] MAX_NAME_LEN_RESET = 8'd80;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_NAME = 2'd1;
  localparam logic [1:0] KIND_DATE = 2'd2;
  localparam logic [1:0] KIND_TIME = 2'd3;

  localparam logic [1:0] VERDICT_PARSING = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
  localparam logic [1:0] VERDICT_REJECTED = 2'd2;

  typedef struct packed {
    logic [1:0] field_kind;
    logic [7:0] field_index;
    logic [7:0] echo_byte;
    logic [1:0] verdict;
  } bhp_result_t;

endpackage

### src/bhp_parser.sv
// Parse state of the header checker and the result for the byte on its inputs.
module bhp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 start_flag_i,
  input  logic [7:0]           max_name_len_i,
  output bhp_pkg::bhp_result_t result_o
);
  import bhp_pkg::*;

  typedef enum logic [3:0] {
    PH_MAGIC0, PH_MAGIC1, PH_SKIP, PH_AHDR, PH_NLEN_HI, PH_NLEN_LO, PH_NAME,
    PH_BTAG, PH_BLEN_HI, PH_BLEN_LO, PH_BSKIP, PH_CHDR, PH_DATE, PH_DHDR,
    PH_TIME, PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d, phase_c;
  logic [15:0] cnt_q, cnt_d, cnt_c, cnt_inc;
  logic [15:0] len_q, len_d, len_c, len_lo;
  logic [1:0]  verdict_q, verdict_d, verdict_c;
  logic [7:0]  trip_exp;
  logic        trip_ok;
  logic [1:0]  kind;
  logic [7:0]  idx;

  // A start flag restarts the parse before this byte is looked at.
  assign phase_c   = start_flag_i ? PH_MAGIC0 : phase_q;
  assign cnt_c     = start_flag_i ? 16'd0 : cnt_q;
  assign len_c     = start_flag_i ? 16'd0 : len_q;
  assign verdict_c = start_flag_i ? VERDICT_PARSING : verdict_q;
  assign cnt_inc   = cnt_c + 16'd1;
  assign len_lo    = {len_c[15:8], data_byte_i};

  always_comb begin
    trip_exp = A_HDR2;
    case (phase_c)
      PH_AHDR: begin
        case (cnt_c[1:0])
          2'd0:    trip_exp = A_HDR0;
          2'd1:    trip_exp = A_HDR1;
          default: trip_exp = A_HDR2;
        endcase
      end
      PH_CHDR: begin
        case (cnt_c[1:0])
          2'd0:    trip_exp = C_TAG;
          2'd1:    trip_exp = 8'h00;
          default: trip_exp = DATE_LEN[7:0];
        endcase
      end
      default: begin
        case (cnt_c[1:0])
          2'd0:    trip_exp = D_TAG;
          2'd1:    trip_exp = 8'h00;
          default: trip_exp = TIME_LEN[7:0];
        endcase
      end
    endcase
  end

  assign trip_ok = (cnt_c <= 16'd2) && (data_byte_i == trip_exp);

  always_comb begin
    phase_d   = phase_c;
    cnt_d     = cnt_c;
    len_d     = len_c;
    verdict_d = verdict_c;
    kind      = KIND_FRAME;
    idx       = 8'd0;
    case (phase_c)
      PH_MAGIC0: begin
        if (data_byte_i == MAGIC0_BYTE) begin
          phase_d = PH_MAGIC1;
        end else begin
          phase_d = PH_DONE;
          verdict_d = VERDICT_REJECTED;
        end
      end
      PH_MAGIC1: begin
        if (data_byte_i == MAGIC1_BYTE) begin
          phase_d = PH_SKIP;
          cnt_d = 16'd0;
        end else begin
          phase_d = PH_DONE;
          verdict_d = VERDICT_REJECTED;
        end
      end
      PH_SKIP: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= SKIP_LEN) begin
          cnt_d = 16'd0;
          phase_d = PH_AHDR;
        end
      end
      PH_AHDR, PH_CHDR, PH_DHDR: begin
        if (!trip_ok) begin
          phase_d = PH_DONE;
          verdict_d = VERDICT_REJECTED;
        end else if (cnt_c[1:0] == 2'd2) begin
          cnt_d = 16'd0;
          phase_d = (phase_c == PH_AHDR) ? PH_NLEN_HI :
                    (phase_c == PH_CHDR) ? PH_DATE : PH_TIME;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_NLEN_HI: begin
        len_d = {data_byte_i, 8'h00};
        phase_d = PH_NLEN_LO;
      end
      PH_NLEN_LO: begin
        len_d = len_lo;
        cnt_d = 16'd0;
        if (len_lo > {8'h00, max_name_len_i}) begin
          phase_d = PH_DONE;
          verdict_d = VERDICT_REJECTED;
        end else begin
          phase_d = (len_lo == 16'd0) ? PH_BTAG : PH_NAME;
        end
      end
      PH_NAME: begin
        kind = KIND_NAME;
        idx = cnt_c[7:0];
        cnt_d = cnt_inc;
        if (cnt_inc >= len_c) begin
          cnt_d = 16'd0;
          phase_d = PH_BTAG;
        end
      end
      PH_BTAG: begin
        if (data_byte_i == B_TAG) begin
          phase_d = PH_BLEN_HI;
        end else begin
          phase_d = PH_DONE;
          verdict_d = VERDICT_REJECTED;
        end
      end
      PH_BLEN_HI: begin
        len_d = {data_byte_i, 8'h00};
        phase_d = PH_BLEN_LO;
      end
      PH_BLEN_LO: begin
        len_d = len_lo;
        cnt_d = 16'd0;
        phase_d = (len_lo == 16'd0) ? PH_CHDR : PH_BSKIP;
      end
      PH_BSKIP: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= len_c) begin
          cnt_d = 16'd0;
          phase_d = PH_CHDR;
        end
      end
      PH_DATE: begin
        kind = KIND_DATE;
        idx = cnt_c[7:0];
        cnt_d = cnt_inc;
        if (cnt_inc >= DATE_LEN) begin
          cnt_d = 16'd0;
          phase_d = PH_DHDR;
        end
      end
      PH_TIME: begin
        kind = KIND_TIME;
        idx = cnt_c[7:0];
        cnt_d = cnt_inc;
        if (cnt_inc >= TIME_LEN) begin
          cnt_d = 16'd0;
          phase_d = PH_DONE;
          verdict_d = VERDICT_ACCEPTED;
        end
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
  end

  assign result_o.field_kind  = kind;
  assign result_o.field_index = idx;
  assign result_o.echo_byte   = data_byte_i;
  assign result_o.verdict     = verdict_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC0;
      cnt_q     <= 16'd0;
      len_q     <= 16'd0;
      verdict_q <= VERDICT_PARSING;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      verdict_q <= verdict_d;
    end
  end

endmodule

### src/bitstream_header_parser_top.sv
// Top level of the configuration file header parser.
//
// Header bytes enter on the input channel (in_valid_i / in_stall_o) with
// data_byte_i and start_flag_i; a set start flag restarts the parse on that
// byte. Every input transfer yields exactly one result on the output channel
// (out_valid_o / out_stall_i): the byte's role and position, the byte itself
// and the verdict as it stands after the byte.
// A byte's result is registered and offered from the cycle after the byte
// is taken. Throughput is one byte per cycle unless the receiver stalls,
// set by the single output register behind the per-byte parse logic; a new
// byte is taken in the same cycle in which the waiting result is transferred.
// While the receiver stalls, the result register holds and in_stall_o is
// raised, so no byte is taken until the result has gone.
// The cfg channel writes max_name_length; it is always ready and should be
// written only while the block is idle.
// Reset clears the parse state to the first magic byte, sets the verdict to
// parsing, clears the output valid flag and loads max_name_length with 80.
`include "assert_macros.svh"

module bitstream_header_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_flag_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] field_kind_o,
  output logic [7:0] field_index_o,
  output logic [7:0] echo_byte_o,
  output logic [1:0] verdict_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);
  import bhp_pkg::*;

  logic        in_xfer;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  max_name_len_q;
  bhp_result_t step_res;
  bhp_result_t res_q;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_valid_d = in_xfer | (out_valid_q & out_stall_i);
  assign cfg_ready_o = 1'b1;

  bhp_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_xfer),
    .data_byte_i    (data_byte_i),
    .start_flag_i   (start_flag_i),
    .max_name_len_i (max_name_len_q),
    .result_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      max_name_len_q <= MAX_NAME_LEN_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_name_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign field_kind_o  = res_q.field_kind;
  assign field_index_o = res_q.field_index;
  assign echo_byte_o   = res_q.echo_byte;
  assign verdict_o     = res_q.verdict;

  // Tagged bytes are only ever seen while parsing, or on the final time byte.
  `BHP_ASSERT(a_tagged_verdict, clk_i, rst_ni, (out_valid_o && field_kind_o != KIND_FRAME) |-> (verdict_o == VERDICT_PARSING || (field_kind_o == KIND_TIME && verdict_o == VERDICT_ACCEPTED)))
  `BHP_ASSERT(a_frame_index, clk_i, rst_ni, (out_valid_o && field_kind_o == KIND_FRAME) |-> (field_index_o == 8'd0))
  `BHP_ASSERT(a_result_follows, clk_i, rst_ni, in_xfer |=> out_valid_o)
  `BHP_ASSERT_NEVER(a_stall_cause, clk_i, rst_ni, in_stall_o && !(out_valid_o && out_stall_i))

endmodule
